// ===== rtl/core/arrt_pkg.sv =====
// Shared types, codes and helpers for the address region reservation table.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none
package arrt_pkg;

    localparam int MAX_REGIONS = 64;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int CNT_W       = IDX_W + 1;

    // operation codes
    localparam logic [2:0] KIND_ALLOC   = 3'd0;
    localparam logic [2:0] KIND_RESERVE = 3'd1;
    localparam logic [2:0] KIND_QUERY   = 3'd2;
    localparam logic [2:0] KIND_FIND    = 3'd3;
    localparam logic [2:0] KIND_RELEASE = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOSPACE  = 3'd1;
    localparam logic [2:0] ST_OVERLAP  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_FIRST = 2'd0;
    localparam logic [1:0] CFG_LIMIT = 2'd1;
    localparam logic [1:0] CFG_GRAN  = 2'd2;

    localparam logic [32:0] SPACE_TOP = 33'h1_0000_0000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] address;
        logic [31:0] length;
        logic [4:0]  align_log2;
    } arrt_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        is_reserved;
        logic [31:0] region_start;
        logic [32:0] region_length;
    } arrt_out_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
    } arrt_entry_t;

    // compare unit results
    typedef struct packed {
        logic        s_ge_key;
        logic        gap_ok;
        logic        s_le_key;
        logic        s_eq_key;
        logic        s_lt_kend;
        logic        key_lt_end;
        logic        kend_le_end;
        logic [32:0] e_end;
        logic [33:0] end_aligned;
        logic [34:0] kend;
    } arrt_cmp_t;

    function automatic logic [33:0] round_to_align(input logic [33:0] v, input logic [4:0] lg);
        logic [33:0] m;
        m = (34'd1 << lg) - 34'd1;
        return (v + m) & ~m;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/arrt_table.sv =====
// Region table storage: one write port, one registered read port.
// Depends on arrt_pkg.
`default_nettype none
module arrt_table
    import arrt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_addr,
    input  wire arrt_entry_t       wr_data,
    input  wire logic [IDX_W-1:0]  rd_addr,
    output arrt_entry_t            rd_data
);

    arrt_entry_t mem [MAX_REGIONS];

    // write one entry, read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/arrt_cmp_unit.sv =====
// Shared compare/add unit: checks one table entry against a key range.
// Depends on arrt_pkg.
`default_nettype none
module arrt_cmp_unit
    import arrt_pkg::*;
(
    input  wire arrt_entry_t  entry,
    input  wire logic [33:0]  key,
    input  wire logic [31:0]  klen,
    input  wire logic [4:0]   lg,
    output arrt_cmp_t         res
);

    logic [33:0] s_x;

    assign s_x = {2'b00, entry.start};

    // form the entry end, the key end and all orderings between them
    always_comb
    begin
        res.e_end       = {1'b0, entry.start} + {1'b0, entry.length};
        res.kend        = {1'b0, key} + {3'b000, klen};
        res.end_aligned = round_to_align({1'b0, res.e_end}, lg);
        res.s_ge_key    = (s_x >= key);
        res.gap_ok      = (s_x >= key) && (res.kend <= {1'b0, s_x});
        res.s_le_key    = (s_x <= key);
        res.s_eq_key    = (s_x == key);
        res.s_lt_kend   = ({1'b0, s_x} < res.kend);
        res.key_lt_end  = (key < {1'b0, res.e_end});
        res.kend_le_end = (res.kend <= {2'b00, res.e_end});
    end

endmodule
`default_nettype wire

// ===== rtl/core/address_region_reservation_table_unit.sv =====
// Top level of the address region reservation table: sequencer, config, output register.
// Depends on arrt_pkg, arrt_table and arrt_cmp_unit.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_stall    in_data  (arrt_in_t)
//   out       output     out_valid / out_stall  out_data (arrt_out_t)
//   cfg       input      cfg_write              cfg_index, cfg_data
//
// One item at a time; in_stall stays high from the transfer until the sequencer
// is idle again. Each walk visits one table entry per cycle through the registered
// table read and the shared compare unit. Reset idles the sequencer, clears the
// output valid flag and the region count and loads the config defaults.
// A stalled result holds in the output register; the sequencer waits for it.
`default_nettype none
module address_region_reservation_table_unit
    import arrt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire arrt_in_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output arrt_out_t        out_data,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    typedef enum logic [3:0] {
        IDLE, ALLOC_WALK, RES_WALK, POS_START, POS_WALK, INS_START, INS_SHIFT,
        LOOK_WALK, LOOK_FIN, REL_WALK, REL_SHIFT, DONE
    } state_t;

    state_t           state_reg;
    logic [31:0]      first_reg;
    logic [31:0]      limit_reg;
    logic [4:0]       gran_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] pos_reg;
    logic [2:0]       kind_reg;
    logic [31:0]      addr_reg;
    logic [31:0]      len_reg;
    logic [4:0]       lg_reg;
    logic [33:0]      cand_reg;
    logic [31:0]      ins_start_reg;
    logic [31:0]      ins_len_reg;
    arrt_entry_t      prev_reg;
    logic             have_prev_reg;
    logic             dup_reg;
    logic             ovl_reg;
    logic [32:0]      nxt_reg;
    arrt_out_t        res_reg;
    logic             out_valid_reg;
    arrt_out_t        out_reg;

    arrt_entry_t      rd_q;
    arrt_entry_t      wr_data;
    arrt_entry_t      cmp_entry;
    arrt_cmp_t        cmp;
    logic [33:0]      cmp_key;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    logic             at_end;
    logic [4:0]       in_lg;
    logic [32:0]      in_end;
    logic [2:0]       in_status;
    logic             accept;

    assign in_stall  = (state_reg != IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign at_end    = (idx_reg == count_reg);
    assign in_lg     = (in_data.align_log2 > gran_reg) ? in_data.align_log2 : gran_reg;
    assign in_end    = {1'b0, in_data.address} + {1'b0, in_data.length};

    // status an item starts with: early rejects, otherwise not found
    always_comb
    begin
        in_status = ST_NOTFOUND;
        if ((in_data.kind == KIND_ALLOC || in_data.kind == KIND_RESERVE)
            && count_reg >= CNT_W'(MAX_REGIONS))
        begin
            in_status = ST_FULL;
        end
        else if (in_data.kind == KIND_RESERVE && in_end > SPACE_TOP)
        begin
            in_status = ST_NOSPACE;
        end
    end

    // pick the key and entry that the compare unit looks at
    always_comb
    begin
        cmp_entry = (state_reg == LOOK_FIN) ? prev_reg : rd_q;
        case (state_reg)
            ALLOC_WALK: cmp_key = cand_reg;
            POS_WALK:   cmp_key = {2'b00, ins_start_reg};
            default:    cmp_key = {2'b00, addr_reg};
        endcase
    end

    // table read address and write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = idx_reg[IDX_W-1:0];
        wr_data = rd_q;
        case (state_reg)
            IDLE, POS_START: rd_idx = '0;
            INS_START:       rd_idx = IDX_W'(idx_reg - CNT_W'(1));
            INS_SHIFT:       rd_idx = IDX_W'(idx_reg - CNT_W'(2));
            REL_SHIFT:       rd_idx = IDX_W'(idx_reg + CNT_W'(2));
            default:         rd_idx = IDX_W'(idx_reg + CNT_W'(1));
        endcase
        if (state_reg == INS_SHIFT)
        begin
            wr_en = 1'b1;
            if (idx_reg <= pos_reg)
            begin
                wr_idx  = pos_reg[IDX_W-1:0];
                wr_data = '{start: ins_start_reg, length: ins_len_reg};
            end
        end
        if (state_reg == REL_SHIFT && (idx_reg + CNT_W'(1)) < count_reg)
        begin
            wr_en = 1'b1;
        end
    end

    arrt_table u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx),
        .wr_data (wr_data),
        .rd_addr (rd_idx),
        .rd_data (rd_q)
    );

    arrt_cmp_unit u_cmp (
        .entry (cmp_entry),
        .key   (cmp_key),
        .klen  (len_reg),
        .lg    (lg_reg),
        .res   (cmp)
    );

    // sequencer, config registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            first_reg     <= 32'h0001_0000;
            limit_reg     <= 32'h7FFF_0000;
            gran_reg      <= 5'd16;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // config writes
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_FIRST: first_reg <= cfg_data;
                    CFG_LIMIT: limit_reg <= cfg_data;
                    CFG_GRAN:  gran_reg  <= cfg_data[4:0];
                    default:   ;
                endcase
            end

            // drop a result once it is taken, unless a new one replaces it
            if (out_valid_reg && !out_stall && state_reg != DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg      <= in_data.kind;
                        addr_reg      <= in_data.address;
                        len_reg       <= in_data.length;
                        lg_reg        <= in_lg;
                        cand_reg      <= round_to_align({2'b00, first_reg}, in_lg);
                        idx_reg       <= '0;
                        have_prev_reg <= 1'b0;
                        dup_reg       <= 1'b0;
                        ovl_reg       <= 1'b0;
                        res_reg       <= '{status: in_status, default: '0};
                        if (in_status != ST_NOTFOUND)
                        begin
                            state_reg <= DONE;
                        end
                        else
                        begin
                            case (in_data.kind)
                                KIND_ALLOC:            state_reg <= ALLOC_WALK;
                                KIND_RESERVE:          state_reg <= RES_WALK;
                                KIND_QUERY, KIND_FIND: state_reg <= LOOK_WALK;
                                KIND_RELEASE:          state_reg <= REL_WALK;
                                default:               state_reg <= DONE;
                            endcase
                        end
                    end
                end

                // first-fit search over the sorted regions
                ALLOC_WALK:
                begin
                    if (at_end)
                    begin
                        if (cmp.kend > {3'b000, limit_reg})
                        begin
                            res_reg.status <= ST_NOSPACE;
                            state_reg      <= DONE;
                        end
                        else
                        begin
                            ins_start_reg <= cand_reg[31:0];
                            ins_len_reg   <= len_reg;
                            state_reg     <= POS_START;
                        end
                    end
                    else if (cmp.gap_ok)
                    begin
                        ins_start_reg <= cand_reg[31:0];
                        ins_len_reg   <= len_reg;
                        state_reg     <= POS_START;
                    end
                    else
                    begin
                        cand_reg <= cmp.end_aligned;
                        idx_reg  <= idx_reg + CNT_W'(1);
                    end
                end

                // overlap check against every region
                RES_WALK:
                begin
                    if (at_end)
                    begin
                        if (ovl_reg)
                        begin
                            res_reg.status <= ST_OVERLAP;
                            state_reg      <= DONE;
                        end
                        else
                        begin
                            ins_start_reg <= addr_reg;
                            ins_len_reg   <= len_reg;
                            state_reg     <= POS_START;
                        end
                    end
                    else
                    begin
                        if (cmp.s_lt_kend && cmp.key_lt_end)
                        begin
                            ovl_reg <= 1'b1;
                        end
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                end

                POS_START:
                begin
                    idx_reg   <= '0;
                    dup_reg   <= 1'b0;
                    state_reg <= POS_WALK;
                end

                // find the insertion point and reject a duplicate start
                POS_WALK:
                begin
                    if (!at_end && cmp.s_le_key)
                    begin
                        dup_reg <= cmp.s_eq_key;
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                    else if (dup_reg)
                    begin
                        res_reg.status <= ST_OVERLAP;
                        state_reg      <= DONE;
                    end
                    else
                    begin
                        pos_reg   <= idx_reg;
                        idx_reg   <= count_reg;
                        state_reg <= INS_START;
                    end
                end

                INS_START: state_reg <= INS_SHIFT;

                // move entries up one slot, then drop the new one in
                INS_SHIFT:
                begin
                    if (idx_reg > pos_reg)
                    begin
                        idx_reg <= idx_reg - CNT_W'(1);
                    end
                    else
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        res_reg   <= '{status: ST_OK, is_reserved: 1'b0,
                                       region_start: ins_start_reg,
                                       region_length: {1'b0, ins_len_reg}};
                        state_reg <= DONE;
                    end
                end

                // locate the last region starting at or below the address
                LOOK_WALK:
                begin
                    if (!at_end && cmp.s_le_key)
                    begin
                        prev_reg      <= rd_q;
                        have_prev_reg <= 1'b1;
                        idx_reg       <= idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        nxt_reg   <= at_end ? SPACE_TOP : {1'b0, rd_q.start};
                        state_reg <= LOOK_FIN;
                    end
                end

                LOOK_FIN:
                begin
                    state_reg <= DONE;
                    if (kind_reg == KIND_QUERY)
                    begin
                        res_reg.status <= ST_OK;
                        if (!have_prev_reg)
                        begin
                            res_reg.region_start  <= '0;
                            res_reg.region_length <= nxt_reg;
                        end
                        else if (cmp.key_lt_end)
                        begin
                            res_reg.is_reserved   <= 1'b1;
                            res_reg.region_start  <= prev_reg.start;
                            res_reg.region_length <= {1'b0, prev_reg.length};
                        end
                        else
                        begin
                            res_reg.region_start  <= cmp.e_end[31:0];
                            res_reg.region_length <= nxt_reg - cmp.e_end;
                        end
                    end
                    else if (have_prev_reg && cmp.kend_le_end)
                    begin
                        res_reg.status        <= ST_OK;
                        res_reg.region_start  <= prev_reg.start;
                        res_reg.region_length <= {1'b0, prev_reg.length};
                    end
                end

                // search for the start to release
                REL_WALK:
                begin
                    if (at_end)
                    begin
                        state_reg <= DONE;
                    end
                    else if (cmp.s_eq_key)
                    begin
                        res_reg   <= '{status: ST_OK, is_reserved: 1'b0,
                                       region_start: rd_q.start,
                                       region_length: {1'b0, rd_q.length}};
                        state_reg <= REL_SHIFT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                end

                // close the gap one entry per cycle
                REL_SHIFT:
                begin
                    if ((idx_reg + CNT_W'(1)) < count_reg)
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= DONE;
                    end
                end

                // hand the result to the output register
                DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg       <= res_reg;
                        state_reg     <= IDLE;
                    end
                end

                default: state_reg <= IDLE;
            endcase
        end
    end

    // region count stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_REGIONS))
        else $error("region count beyond table depth");

    // an accepted transfer always starts work
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != IDLE)
        else $error("accepted item left sequencer idle");

    // a new result appears only out of the completion state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == DONE))
        else $error("result raised outside completion");

    // the count moves only while inserting or releasing
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            ($past(state_reg == INS_SHIFT) || $past(state_reg == REL_SHIFT)))
        else $error("region count changed outside table update");

endmodule
`default_nettype wire

// ===== dv/address_region_reservation_table_unit_test.sv =====
// Self-checking testbench for the address region reservation table unit.
// Depends on arrt_pkg and address_region_reservation_table_unit.
`timescale 1ns / 100ps
`default_nettype none
module address_region_reservation_table_unit_test;
    import arrt_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    arrt_in_t    in_data;
    logic        out_valid;
    logic        out_stall;
    arrt_out_t   out_data;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // shadow of the table and registers
    logic [31:0] shadow_start [MAX_REGIONS];
    logic [31:0] shadow_len [MAX_REGIONS];
    int          shadow_count;
    logic [32:0] model_first;
    logic [32:0] model_limit;
    logic [4:0]  model_gran;

    arrt_out_t   pending_results [$];
    int          error_count;
    int          burst_left;
    bit          stall_free;

    address_region_reservation_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [34:0] round_up(input logic [34:0] v, input int lg);
        logic [34:0] m;
        m = (35'd1 << lg) - 35'd1;
        return (v + m) & ~m;
    endfunction

    // count of entries whose start is at or below a
    function automatic int upper_index(input logic [34:0] a);
        int i;
        i = 0;
        while (i < shadow_count && {3'b0, shadow_start[i]} <= a)
            i++;
        return i;
    endfunction

    function automatic logic [34:0] end_at(input int i);
        return {3'b0, shadow_start[i]} + {3'b0, shadow_len[i]};
    endfunction

    function automatic logic [2:0] insert_region(input logic [34:0] s, input logic [31:0] l);
        int p;
        if (shadow_count >= MAX_REGIONS)
            return ST_FULL;
        p = upper_index(s);
        if (p > 0 && {3'b0, shadow_start[p - 1]} == s)
            return ST_OVERLAP;
        for (int i = shadow_count; i > p; i--)
        begin
            shadow_start[i] = shadow_start[i - 1];
            shadow_len[i] = shadow_len[i - 1];
        end
        shadow_start[p] = s[31:0];
        shadow_len[p] = l;
        shadow_count++;
        return ST_OK;
    endfunction

    // compute the result of one operation and update the shadow table
    function automatic arrt_out_t predict_region_op(input arrt_in_t op);
        arrt_out_t   r;
        int          lg;
        int          p;
        bit          hit;
        logic [34:0] cand;
        logic [34:0] a;
        logic [34:0] l;
        logic [34:0] hi;
        logic [34:0] e;
        r = '0;
        r.status = ST_NOTFOUND;
        a = {3'b0, op.address};
        l = {3'b0, op.length};
        case (op.kind)
            KIND_ALLOC:
            begin
                lg = (op.align_log2 > model_gran) ? op.align_log2 : model_gran;
                cand = round_up({2'b0, model_first}, lg);
                hit = 0;
                if (shadow_count >= MAX_REGIONS)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = 0; i < shadow_count && !hit; i++)
                    begin
                        if ({3'b0, shadow_start[i]} >= cand
                            && {3'b0, shadow_start[i]} - cand >= l)
                            hit = 1;
                        else
                            cand = round_up(end_at(i), lg);
                    end
                    if (!hit && cand + l > {2'b0, model_limit})
                        r.status = ST_NOSPACE;
                    else
                        r.status = insert_region(cand, op.length);
                    if (r.status == ST_OK)
                    begin
                        r.region_start = cand[31:0];
                        r.region_length = l[32:0];
                    end
                end
            end
            KIND_RESERVE:
            begin
                if (shadow_count >= MAX_REGIONS)
                    r.status = ST_FULL;
                else if (a + l > {2'b0, SPACE_TOP})
                    r.status = ST_NOSPACE;
                else
                begin
                    r.status = ST_OK;
                    for (int i = 0; i < shadow_count; i++)
                        if ({3'b0, shadow_start[i]} < a + l && a < end_at(i))
                            r.status = ST_OVERLAP;
                    if (r.status == ST_OK)
                        r.status = insert_region(a, op.length);
                    if (r.status == ST_OK)
                    begin
                        r.region_start = op.address;
                        r.region_length = l[32:0];
                    end
                end
            end
            KIND_QUERY:
            begin
                r.status = ST_OK;
                p = upper_index(a);
                if (p == 0)
                begin
                    r.region_start = '0;
                    r.region_length = (shadow_count == 0) ? SPACE_TOP
                                                          : {1'b0, shadow_start[0]};
                end
                else if (a < end_at(p - 1))
                begin
                    r.is_reserved = 1'b1;
                    r.region_start = shadow_start[p - 1];
                    r.region_length = {1'b0, shadow_len[p - 1]};
                end
                else
                begin
                    hi = (p == shadow_count) ? {2'b0, SPACE_TOP} : {3'b0, shadow_start[p]};
                    e = end_at(p - 1);
                    r.region_start = e[31:0];
                    r.region_length = 33'(hi - e);
                end
            end
            KIND_FIND:
            begin
                p = upper_index(a);
                if (p > 0 && a + l <= end_at(p - 1))
                begin
                    r.status = ST_OK;
                    r.region_start = shadow_start[p - 1];
                    r.region_length = {1'b0, shadow_len[p - 1]};
                end
            end
            KIND_RELEASE:
            begin
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_start[i] == op.address)
                    begin
                        r.status = ST_OK;
                        r.region_start = shadow_start[i];
                        r.region_length = {1'b0, shadow_len[i]};
                        for (int j = i; j + 1 < shadow_count; j++)
                        begin
                            shadow_start[j] = shadow_start[j + 1];
                            shadow_len[j] = shadow_len[j + 1];
                        end
                        shadow_count--;
                        break;
                    end
                end
            end
            default:
                r.status = ST_NOTFOUND;
        endcase
        return r;
    endfunction

    // send one operation; the sender works in bursts with random gaps
    task automatic send_op(input arrt_in_t op);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= op;
        pending_results.push_back(predict_region_op(op));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_fields(input logic [2:0] k, input logic [31:0] a,
                               input logic [31:0] l, input logic [4:0] g);
        arrt_in_t op;
        op.kind = k;
        op.address = a;
        op.length = l;
        op.align_log2 = g;
        send_op(op);
    endtask

    // wait for every expected result, then let the sequencer settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
        drain_results();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_FIRST: model_first = {1'b0, val};
            CFG_LIMIT: model_limit = {1'b0, val};
            CFG_GRAN:  model_gran = val[4:0];
            default: ;
        endcase
    endtask

    // random length, mostly small and page-aligned
    function automatic logic [31:0] pick_length();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return $urandom();
            2: return $urandom_range(1, 8) << 24;
            default: return $urandom_range(1, 16) << 12;
        endcase
    endfunction

    // directed corner cases
    task automatic test_directed();
        send_fields(KIND_QUERY, 32'h1234_5678, '0, '0);
        send_fields(KIND_FIND, '0, '0, '0);
        send_fields(KIND_RELEASE, '0, '0, '0);
        send_fields(KIND_ALLOC, '0, 32'h0000_1000, 5'd0);
        send_fields(KIND_ALLOC, '0, 32'h0001_0000, 5'd31);
        send_fields(KIND_RESERVE, 32'hFFFF_F000, 32'h0000_1000, '0);
        send_fields(KIND_RESERVE, 32'hFFFF_F000, 32'h0000_2000, '0);
        send_fields(KIND_RESERVE, 32'h0000_0000, 32'hFFFF_FFFF, '0);
        send_fields(KIND_RESERVE, 32'h0002_0000, 32'h0000_0000, '0);
        send_fields(KIND_RESERVE, 32'h0002_0000, 32'h0000_0000, '0);
        send_fields(KIND_RESERVE, 32'h0001_8000, 32'h0001_0000, '0);
        send_fields(KIND_QUERY, 32'h0000_0000, '0, '0);
        send_fields(KIND_QUERY, 32'h0001_0800, '0, '0);
        send_fields(KIND_QUERY, 32'hFFFF_FFFF, '0, '0);
        send_fields(KIND_QUERY, 32'h8000_0000, '0, '0);
        send_fields(KIND_FIND, 32'h0001_0000, 32'h0000_1000, '0);
        send_fields(KIND_FIND, 32'hFFFF_F000, 32'hFFFF_FFFF, '0);
        send_fields(KIND_ALLOC, '0, 32'hFFFF_FFFF, 5'd12);
        send_fields(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
        send_fields(3'd7, '0, '0, '0);
        send_fields(KIND_RELEASE, 32'hFFFF_F000, '0, '0);
        send_fields(KIND_RELEASE, 32'h0002_0000, '0, '0);
        send_fields(KIND_RELEASE, 32'h0000_1234, '0, '0);
    endtask

    // fill the table to capacity, then overflow and release some
    task automatic test_table_full();
        for (int i = 0; i < MAX_REGIONS + 2; i++)
            send_fields(KIND_ALLOC, '0, 32'h0000_1000, 5'd0);
        send_fields(KIND_RESERVE, 32'hF000_0000, 32'h0000_1000, '0);
        drain_results();
        for (int i = 0; i < 40; i++)
            send_fields(KIND_RELEASE, 32'h0001_0000 + ($urandom_range(0, 70) << 16), '0, '0);
    endtask

    // random operations; probes mostly reuse known region edges
    task automatic test_random(input int count);
        logic [2:0]  k;
        logic [31:0] a;
        int          p;
        for (int n = 0; n < count; n++)
        begin
            k = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
            if (shadow_count != 0 && $urandom_range(0, 3) != 0)
            begin
                p = $urandom_range(0, shadow_count - 1);
                a = shadow_start[p] + (($urandom_range(0, 1) != 0) ? shadow_len[p]
                                                               : ($urandom_range(0, 3) << 12));
            end
            else
                a = $urandom();
            if (n == count / 2)
                drain_results();
            send_fields(k, a, pick_length(), 5'($urandom()));
        end
    endtask

    // check each result against the oldest expectation
    always @(posedge clk)
    begin
        arrt_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, out_data.status);
                    error_count++;
                end
                if (out_data.is_reserved !== want.is_reserved)
                begin
                    $error("is_reserved expected %0d actual %0d",
                           want.is_reserved, out_data.is_reserved);
                    error_count++;
                end
                if (out_data.region_start !== want.region_start)
                begin
                    $error("region_start expected %h actual %h",
                           want.region_start, out_data.region_start);
                    error_count++;
                end
                if (out_data.region_length !== want.region_length)
                begin
                    $error("region_length expected %h actual %h",
                           want.region_length, out_data.region_length);
                    error_count++;
                end
            end
        end
    end

    // receiver stall pattern with quiet stretches
    always @(posedge clk)
    begin
        if ($urandom_range(0, 99) == 0)
            stall_free <= ~stall_free;
        out_stall <= stall_free ? 1'b0 : ($urandom_range(0, 2) == 0);
    end

    initial
    begin
        #50ms;
        $display("address_region_reservation_table_unit_test: FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_FIRST;
        cfg_data = '0;
        error_count = 0;
        burst_left = 0;
        shadow_count = 0;
        model_first = 33'h0001_0000;
        model_limit = 33'h7FFF_0000;
        model_gran = 5'd16;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_register(CFG_GRAN, 32'd12);
        write_register(CFG_FIRST, 32'h0000_0000);
        test_table_full();
        write_register(CFG_LIMIT, 32'hFFFF_FFFF);
        test_random(200);
        write_register(CFG_GRAN, 32'd31);
        write_register(CFG_FIRST, 32'hFFFF_FFFF);
        test_random(60);
        write_register(CFG_GRAN, 32'hFFFF_FFEC);
        write_register(CFG_FIRST, 32'h0123_4567);
        write_register(CFG_LIMIT, 32'h0000_0000);
        test_random(60);
        write_register(CFG_LIMIT, 32'h4000_0000);
        write_register(CFG_GRAN, 32'd13);
        test_random(150);

        drain_results();
        if (error_count == 0)
            $display("address_region_reservation_table_unit_test: PASS");
        else
            $display("address_region_reservation_table_unit_test: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/arrt_pkg.sv
rtl/core/arrt_table.sv
rtl/core/arrt_cmp_unit.sv
rtl/core/address_region_reservation_table_unit.sv
dv/address_region_reservation_table_unit_test.sv
